>>> hdl/tad_pkg.sv
// ============================================================================
// tad_pkg
// Shared types and constants for the accelerometer tap detector.
// ============================================================================
package tad_pkg;

    // Default sizes
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_TIME_BITS   = 32;
    localparam int DEF_COUNT_BITS  = 16;

    // Configuration register layout
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_DELTA_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REFRACTORY_MS   = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] DELTA_THRESHOLD_RST = 16'd24576; // 1.5 g
    localparam logic [CFG_DATA_BITS-1:0] REFRACTORY_MS_RST   = 16'd300;

    // Result field width
    localparam int OUT_BITS = 16;

    // Axis select codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DECIDE
    } tad_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic       capture;    // latch input beat, clear accumulator
        logic       square;     // square one axis, accumulate previous square
        logic [1:0] axis_sel;
        logic       root_load;  // final add, load radicand
        logic       root_step;  // one square-root digit
        logic       commit;     // update state, load output register
    } tad_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_busy;         // output register full and not being taken
    } tad_stat_t;

endpackage

>>> hdl/accel_tap_detector_unit.sv
// ============================================================================
// accel_tap_detector_unit
// Tap detector on the change of three-axis acceleration magnitude.
// ============================================================================
// Usage:
//   Input stream (s_axis_*): one beat per accelerometer sample, carrying the
//   three signed axis readings and a millisecond timestamp in tdata.
//   Output stream (m_axis_*): exactly one beat per input beat, in order:
//   tap count and magnitude change in tdata, tap flag in tuser.
//   Config port: cfg_wr_en/cfg_addr/cfg_wr_data write the threshold
//   (index 0) and the refractory time (index 1); write only while idle.
//   Sequence per sample: capture, three squares on the shared squarer,
//   one final add, one square-root step per result bit, and a decide
//   step; the root iteration is the longest part. One sample at a time:
//   a new sample is taken only after the previous one has committed,
//   and may be taken while that result still sits in the output register.
//   Stall: if m_axis_tready stays low, the finished sample waits in the
//   decide step until the output register frees up; no beat is dropped.
//   Reset (aresetn low, synchronous): registers return to defaults,
//   previous magnitude to 1 g, tap count and last tap time to zero, and
//   any beat in flight is discarded.
// ============================================================================
module accel_tap_detector_unit import tad_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    localparam int IN_RAW     = 3 * SAMPLE_BITS + TIME_BITS,
    localparam int IN_BITS    = ((IN_RAW + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // low to high: accel_x, accel_y, accel_z, timestamp_ms, zero pad
    input  logic [IN_BITS-1:0]       s_axis_tdata,
    // result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // low to high: tap_total, strength
    output logic [2*OUT_BITS-1:0]    m_axis_tdata,
    // tap_seen
    output logic                     m_axis_tuser,
    // configuration writes
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data
);

    tad_cmd_t  cmd;
    tad_stat_t stat;

    logic [CFG_DATA_BITS-1:0] threshold_reg;
    logic [CFG_DATA_BITS-1:0] refractory_reg;

    logic [OUT_BITS-1:0] tap_total;
    logic [OUT_BITS-1:0] strength;

    // Config registers; the 1-bit index covers both registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= DELTA_THRESHOLD_RST;
            refractory_reg <= REFRACTORY_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DELTA_THRESHOLD: threshold_reg  <= cfg_wr_data;
                REG_REFRACTORY_MS:   refractory_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    tad_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tad_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .accel_x         (s_axis_tdata[0 +: SAMPLE_BITS]),
        .accel_y         (s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS]),
        .accel_z         (s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]),
        .timestamp_ms    (s_axis_tdata[3*SAMPLE_BITS +: TIME_BITS]),
        .delta_threshold (threshold_reg),
        .refractory_ms   (refractory_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .tap_seen        (m_axis_tuser),
        .tap_total       (tap_total),
        .strength        (strength)
    );

    assign m_axis_tdata = {strength, tap_total};

endmodule

>>> hdl/tad_ctrl.sv
// ============================================================================
// tad_ctrl
// Sequencer: capture, three squares, sum, bit-pair square root, decide.
// ============================================================================
module tad_ctrl import tad_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  tad_stat_t stat,
    output tad_cmd_t  cmd
);

    localparam int CNT_BITS = $clog2(SAMPLE_BITS);
    localparam logic [CNT_BITS-1:0] ROOT_LAST = CNT_BITS'(SAMPLE_BITS - 1);
    localparam logic [CNT_BITS-1:0] SQ_LAST   = CNT_BITS'(2);

    tad_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.axis_sel = cnt_reg[1:0];
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == SQ_LAST) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.root_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_LAST) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // wait for room in the output register
                if (!stat.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/tad_dp.sv
// ============================================================================
// tad_dp
// Datapath: axis magnitudes, shared squarer, iterative square root, tap
// decision, detector state and the output register.
// ============================================================================
module tad_dp import tad_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tad_cmd_t                 cmd,
    output tad_stat_t                stat,
    input  logic [SAMPLE_BITS-1:0]   accel_x,
    input  logic [SAMPLE_BITS-1:0]   accel_y,
    input  logic [SAMPLE_BITS-1:0]   accel_z,
    input  logic [TIME_BITS-1:0]     timestamp_ms,
    input  logic [CFG_DATA_BITS-1:0] delta_threshold,
    input  logic [CFG_DATA_BITS-1:0] refractory_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     tap_seen,
    output logic [OUT_BITS-1:0]      tap_total,
    output logic [OUT_BITS-1:0]      strength
);

    localparam int SUM_BITS = 2 * SAMPLE_BITS;
    localparam int REM_BITS = SAMPLE_BITS + 3;
    localparam int DW = (SAMPLE_BITS > OUT_BITS) ? SAMPLE_BITS : OUT_BITS;
    localparam int CW = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam logic [SAMPLE_BITS-1:0] ONE_G = SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);

    // Captured sample
    logic [SAMPLE_BITS-1:0] abs_x_reg, abs_y_reg, abs_z_reg;
    logic [TIME_BITS-1:0]   now_reg;

    // Sum of squares
    logic [SAMPLE_BITS-1:0] sq_in;
    logic [SUM_BITS-1:0]    sq_reg, acc_reg;

    // Square root
    logic [SUM_BITS-1:0]    rad_reg, rad_next;
    logic [REM_BITS-1:0]    rem_reg, rem_next, rem_shift, trial;
    logic [SAMPLE_BITS-1:0] root_reg, root_next;

    // Detector state
    logic [SAMPLE_BITS-1:0] last_mag_reg;
    logic [TIME_BITS-1:0]   last_tap_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    // Decision
    logic [SAMPLE_BITS-1:0] delta;
    logic [DW-1:0]          delta_ext;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   tap;
    logic [COUNT_BITS-1:0]  count_next;
    logic [CW-1:0]          count_ext;

    // Output register
    logic                   out_valid_reg;
    logic                   tap_seen_reg;
    logic [OUT_BITS-1:0]    tap_total_reg, strength_reg;

    function automatic logic [SAMPLE_BITS-1:0] abs_val(input logic [SAMPLE_BITS-1:0] v);
        // most negative value maps to 2^(N-1), still fits unsigned
        return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        case (cmd.axis_sel)
            AXIS_X:  sq_in = abs_x_reg;
            AXIS_Y:  sq_in = abs_y_reg;
            AXIS_Z:  sq_in = abs_z_reg;
            default: sq_in = '0;
        endcase
    end

    // Root digit: bring down two radicand bits, trial subtract 4*root+1
    always_comb begin
        rem_shift = {rem_reg[REM_BITS-3:0], rad_reg[SUM_BITS-1 -: 2]};
        trial     = {REM_BITS'(root_reg) << 2} | REM_BITS'(1);
        rad_next  = rad_reg << 2;
        if (rem_shift >= trial) begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[SAMPLE_BITS-2:0], 1'b1};
        end else begin
            rem_next  = rem_shift;
            root_next = {root_reg[SAMPLE_BITS-2:0], 1'b0};
        end
    end

    always_comb begin
        delta     = (root_reg >= last_mag_reg) ? (root_reg - last_mag_reg)
                                               : (last_mag_reg - root_reg);
        delta_ext = DW'(delta);
        elapsed   = now_reg - last_tap_reg;
        tap       = (delta_ext > DW'(delta_threshold)) &&
                    (elapsed > TIME_BITS'(refractory_ms));
        count_next = (tap && !(&count_reg)) ? (count_reg + 1'b1) : count_reg;
        count_ext  = CW'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            abs_x_reg <= abs_val(accel_x);
            abs_y_reg <= abs_val(accel_y);
            abs_z_reg <= abs_val(accel_z);
            now_reg   <= timestamp_ms;
            sq_reg    <= '0;
            acc_reg   <= '0;
        end else if (cmd.square) begin
            sq_reg  <= SUM_BITS'(sq_in) * SUM_BITS'(sq_in);
            acc_reg <= acc_reg + sq_reg;
        end
        if (cmd.root_load) begin
            rad_reg  <= acc_reg + sq_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.commit) begin
            tap_seen_reg  <= tap;
            tap_total_reg <= (count_ext > CW'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                                                                 : count_ext[OUT_BITS-1:0];
            strength_reg  <= (delta_ext > DW'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                                                                 : delta_ext[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_mag_reg  <= ONE_G;
            last_tap_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                last_mag_reg <= root_reg;
                count_reg    <= count_next;
                if (tap) begin
                    last_tap_reg <= now_reg;
                end
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_busy = out_valid_reg & ~out_ready;
    assign out_valid     = out_valid_reg;
    assign tap_seen      = tap_seen_reg;
    assign tap_total     = tap_total_reg;
    assign strength      = strength_reg;

endmodule

>>> test/tb_accel_tap_detector_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_accel_tap_detector_unit
// Self-checking bench for the accelerometer tap detector.
// ============================================================================
// Drives sample beats into the detector and checks every result beat against
// a cycle-free model of the magnitude / delta / refractory logic kept in a
// small scoreboard class. Starts with hand-picked samples (axis extremes,
// threshold and refractory boundaries, timestamp wrap), then runs random
// phases under several register settings, with random idle bursts on both
// streams and one long receiver hold. The last phase runs with both streams
// flat out.
// ============================================================================
module tb_accel_tap_detector_unit;
    import tad_pkg::*;

    localparam int IN_W        = ((3 * DEF_SAMPLE_BITS + DEF_TIME_BITS + 7) / 8) * 8;
    localparam int LONG_HOLD   = 300;   // receiver hold, long enough to back up the input
    localparam int STALL_LIMIT = 3000;  // cycles without any beat before giving up

    // One sample beat; packed so x lands in the low bits of tdata.
    typedef struct packed {
        bit [31:0] timestamp_ms;
        bit [15:0] accel_z;
        bit [15:0] accel_y;
        bit [15:0] accel_x;
    } accel_sample_t;

    // One result beat: tuser on top, then tdata (tap_total lowest).
    typedef struct packed {
        logic        tap_seen;
        logic [15:0] strength;
        logic [15:0] tap_total;
    } tap_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tap model plus the queue of results still owed by the DUT
    // ------------------------------------------------------------------------
    class tap_tracker;
        bit [15:0]   delta_threshold = DELTA_THRESHOLD_RST;
        bit [15:0]   refractory_ms   = REFRACTORY_MS_RST;
        bit [15:0]   last_mag        = 16'd16384;  // 1 g
        bit [31:0]   last_tap_ms     = '0;
        bit [15:0]   taps            = '0;
        tap_result_t results_due[$];
        int          errors          = 0;

        function void set_reg(logic [CFG_ADDR_BITS-1:0] idx, bit [15:0] val);
            case (idx)
                REG_DELTA_THRESHOLD: delta_threshold = val;
                REG_REFRACTORY_MS:   refractory_ms   = val;
                default: ;
            endcase
        endfunction

        // |raw| of a 16-bit two's complement axis; -32768 gives 32768
        function bit [15:0] axis_size(bit [15:0] raw);
            return raw[15] ? 16'(~raw + 16'd1) : raw;
        endfunction

        function void note_sample(accel_sample_t s);
            bit [31:0]       ax, ay, az, sum_sq, elapsed;
            bit [15:0]       mag, delta;
            longint unsigned trial;
            bit              tap;
            tap_result_t     r;
            ax = axis_size(s.accel_x);
            ay = axis_size(s.accel_y);
            az = axis_size(s.accel_z);
            sum_sq = ax * ax + ay * ay + az * az;  // max 3 * 2^30, fits
            // floor sqrt, one result bit at a time from the top
            mag = '0;
            for (int b = 15; b >= 0; b--) begin
                trial = {48'd0, mag} | (64'd1 << b);
                if (trial * trial <= sum_sq) mag[b] = 1'b1;
            end
            delta   = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
            elapsed = s.timestamp_ms - last_tap_ms;  // wraps mod 2^32
            tap     = (delta > delta_threshold) && (elapsed > {16'd0, refractory_ms});
            if (tap) begin
                if (taps != 16'hFFFF) taps++;
                last_tap_ms = s.timestamp_ms;
            end
            last_mag    = mag;
            r.tap_seen  = tap;
            r.strength  = delta;
            r.tap_total = taps;
            results_due.push_back(r);
        endfunction

        function void mismatch(string field, logic [15:0] want, logic [15:0] got);
            errors++;
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(tap_result_t got);
            tap_result_t want;
            if (results_due.size() == 0) begin
                errors++;
                $error("result beat with no sample pending: %s=%b %s=%0d %s=%0d",
                       "tap_seen", got.tap_seen, "tap_total", got.tap_total,
                       "strength", got.strength);
                return;
            end
            want = results_due.pop_front();
            if (got.tap_seen !== want.tap_seen)
                mismatch("tap_seen", {15'd0, want.tap_seen}, {15'd0, got.tap_seen});
            if (got.tap_total !== want.tap_total)
                mismatch("tap_total", want.tap_total, got.tap_total);
            if (got.strength !== want.strength)
                mismatch("strength", want.strength, got.strength);
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic                     aclk;
    logic                     aresetn;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_W-1:0]          s_axis_tdata;   // low to high: accel_x, accel_y, accel_z, timestamp_ms
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [2*OUT_BITS-1:0]    m_axis_tdata;   // low to high: tap_total, strength
    logic                     m_axis_tuser;   // tap_seen
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data;

    accel_tap_detector_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    tap_tracker book = new();
    bit         idle_on  = 1'b1;  // random idle bursts on both streams
    bit         hold_req = 1'b0;  // one-shot request for a long receiver hold
    int         quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Receiver: ready most of the time, random idle bursts, one long hold
    // ------------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long hold: the sender keeps offering, so the DUT fills and
                // must push back on s_axis_tready
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Result beats are checked at the edge that takes them
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            book.check_result({m_axis_tuser, m_axis_tdata});
    end

    // Watchdog: no beat on either stream for too long means a hang
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic accel_sample_t pack_sample(bit [15:0] x, bit [15:0] y,
                                                  bit [15:0] z, bit [31:0] ts);
        accel_sample_t s;
        s.accel_x      = x;
        s.accel_y      = y;
        s.accel_z      = z;
        s.timestamp_ms = ts;
        return s;
    endfunction

    // Mostly resting near 1 g with sensor noise, random spikes, some corners, zero g
    function automatic accel_sample_t random_sample(bit [31:0] ts);
        accel_sample_t s;
        int            kind;
        s = pack_sample('0, '0, '0, ts);
        kind = $urandom_range(0, 15);
        if (kind < 9) begin
            s.accel_x = 16'($urandom_range(0, 1600)) - 16'd800;
            s.accel_y = 16'($urandom_range(0, 1600)) - 16'd800;
            s.accel_z = ($urandom_range(0, 1) ? 16'd16384 : 16'hC000)
                        + 16'($urandom_range(0, 1600)) - 16'd800;
        end else if (kind < 14) begin
            s.accel_x = 16'($urandom);
            s.accel_y = 16'($urandom);
            s.accel_z = 16'($urandom);
        end else if (kind == 14) begin
            s.accel_x = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            s.accel_y = $urandom_range(0, 1) ? 16'h8000 : 16'hFFFF;
            s.accel_z = $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
        end
        return s;
    endfunction

    // Offer one beat (after an optional idle burst) and wait for it to go in.
    // tvalid is left high; the next call or the drain decides what follows.
    task automatic send_sample(accel_sample_t s);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge aclk); while (!s_axis_tready);
        book.note_sample(s);
    endtask

    // Stop offering and wait until every owed result is back
    task automatic wait_results_done();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, bit [15:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        book.set_reg(idx, val);
    endtask

    // Only called with the pipeline empty
    task automatic apply_config(bit [15:0] thr, bit [15:0] refr);
        write_reg(REG_DELTA_THRESHOLD, thr);
        write_reg(REG_REFRACTORY_MS, refr);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One random phase under a fixed register setting
    task automatic run_phase(int n, bit [15:0] thr, bit [15:0] refr,
                             bit [31:0] t0, bit squeeze);
        bit [31:0] ts;
        ts = t0;
        wait_results_done();
        apply_config(thr, refr);
        for (int i = 0; i < n; i++) begin
            if (squeeze && i == 10) hold_req = 1'b1;
            send_sample(random_sample(ts));
            case ($urandom_range(0, 15))
                0:       ;                             // repeated timestamp
                1:       ts += $urandom;               // big jump, may wrap
                default: ts += $urandom_range(1, 400); // around the refractory window
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_DELTA_THRESHOLD;
        cfg_wr_data   = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset register values (threshold 1.5 g, refractory 300)
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h4000, 32'd0));     // at rest, no change
        send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 32'd100));   // largest magnitude;
                                                                           // too soon after reset
        send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd200));   // all positive max
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'd300));   // elapsed == refractory
        send_sample(pack_sample(16'h8000, 16'h0000, 16'h0000, 32'd301));   // first real tap
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'd302));   // inside refractory
        send_sample(pack_sample(16'd24576, 16'h0000, 16'h0000, 32'd700));  // delta == threshold
        send_sample(pack_sample(16'h9FFF, 16'h0000, 16'h0000, 32'd800));   // -24577, tiny delta
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'd1000));  // threshold + 1: tap
        send_sample(pack_sample(16'h7FFF, 16'h0000, 16'h0000, 32'd1300));  // elapsed == 300
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'd1301));  // elapsed == 301: tap
        send_sample(pack_sample(16'h7FFF, 16'h0000, 16'h0000, 32'hFFFF_FF00)); // tap near wrap
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0020)); // wrapped, 288 ms
        send_sample(pack_sample(16'h7FFF, 16'h0000, 16'h0000, 32'h0000_002D)); // wrapped, 301 ms
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_002D)); // same timestamp
        send_sample(pack_sample(16'h0000, 16'h8000, 16'h0000, 32'h0000_1000)); // y axis only
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h7FFF, 32'h0000_2000)); // z axis only
        send_sample(pack_sample(16'hFFFF, 16'h0001, 16'hFFFF, 32'h0000_3000)); // +-1 counts
        send_sample(pack_sample(16'h5555, 16'hAAAA, 16'h8001, 32'hFFFF_FFFF));
        send_sample(pack_sample(16'hC000, 16'h4000, 16'hC000, 32'h8000_0000));

        // Random phases; the pipeline drains before each register change
        run_phase(70, 16'd12000, 16'd150, $urandom, 1'b0);
        run_phase(60, 16'd0, 16'd0, $urandom, 1'b0);           // any change taps if elapsed > 0
        run_phase(60, 16'hFFFF, 16'd0, $urandom, 1'b0);        // no tap possible
        run_phase(80, 16'($urandom_range(0, 30000)), 16'($urandom), $urandom, 1'b1);
        run_phase(60, DELTA_THRESHOLD_RST, REFRACTORY_MS_RST, 32'hFFFF_F000, 1'b0);

        // Last phase: no idling on either stream
        idle_on = 1'b0;
        run_phase(70, 16'd3000, 16'hFFFF, 32'hFFFF_FFC0, 1'b0);

        // Drain, then allow a full latency for any stray beat
        wait_results_done();
        repeat (30) @(posedge aclk);
        @(negedge aclk);
        if (book.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> accel_tap_detector_unit.f
hdl/tad_pkg.sv
hdl/tad_ctrl.sv
hdl/tad_dp.sv
hdl/accel_tap_detector_unit.sv
test/tb_accel_tap_detector_unit.sv
